// ===== rtl/idop_pkg.sv =====
// idop_pkg: shared constants, register codes and types of the image difference block
// used by every module under rtl; depends on nothing
`default_nettype none

package idop_pkg;

    // sizes
    localparam int WIDTH_MAX    = 1024;
    localparam int HEIGHT_MAX   = 4096;
    localparam int SAMPLE_W     = 16;
    localparam int ALPHA_W      = 16;
    localparam int ALPHA_SQ_W   = 2 * ALPHA_W;
    localparam int VALUE_W      = 50;
    localparam int TDATA_IN_W   = 16;
    localparam int TDATA_OUT_W  = 56;
    localparam int MODE_W       = 3;
    localparam int WIDTH_W      = 11;
    localparam int HEIGHT_W     = 13;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;
    localparam int POS_W        = 23;
    localparam int ROW_W        = POS_W - 1;
    localparam int COL_W        = $clog2(WIDTH_MAX);
    localparam int LINE_DEPTH   = 2 * WIDTH_MAX;
    localparam int ADDR_W       = $clog2(LINE_DEPTH);
    localparam int DIFF_W       = SAMPLE_W + 2;
    localparam int FRAC_SHIFT   = 12;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int DIV_CNT_W    = $clog2(POS_W + 1);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA  = 2'd3;

    // operator codes
    localparam logic [MODE_W-1:0] MODE_DX      = 3'd0;
    localparam logic [MODE_W-1:0] MODE_DX_T    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_DX_SEC  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DY      = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DY_T    = 3'd4;
    localparam logic [MODE_W-1:0] MODE_DY_SEC  = 3'd5;

    // reset values
    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd2;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd1;
    localparam logic [ALPHA_W-1:0]  ALPHA_RESET  = 16'd4096;

    // operator settings seen by the back end
    typedef struct packed {
        logic [MODE_W-1:0]         mode;
        logic signed [ALPHA_W-1:0] alpha;
    } idop_cfg_t;

    // one classified item travelling from front to back
    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic [ADDR_W-1:0]   addr_u;
        logic [ADDR_W-1:0]   addr_0;
        logic [ADDR_W-1:0]   addr_r;
        logic [ADDR_W-1:0]   addr_l;
        logic                has_result;
        logic                first_c;
        logic                last_c;
        logic                first_r;
        logic                last_r;
        logic                frame_end;
    } idop_op_t;

    // front end status
    typedef struct packed {
        logic div_pend;
        logic div_busy;
    } idop_stat_t;

endpackage

`default_nettype wire

// ===== rtl/idop_front.sv =====
// idop_front: configuration registers, position counters and item classification
// depends on idop_pkg; re-divides the position by the new width after a width write
`default_nettype none

module idop_front (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               cfg_we,
    input  wire [idop_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire [idop_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire                               s_tvalid,
    output logic                              s_tready,
    input  wire [idop_pkg::TDATA_IN_W-1:0]    s_tdata,
    input  wire                               q_full,
    output logic                              push,
    output idop_pkg::idop_op_t                push_op,
    output idop_pkg::idop_cfg_t               cfg,
    output idop_pkg::idop_stat_t              stat
);
    import idop_pkg::*;

    logic [MODE_W-1:0]   mode_reg;
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [ALPHA_W-1:0]  alpha_reg;

    logic [POS_W-1:0]    pos_reg;
    logic [COL_W-1:0]    col_reg;
    logic [ROW_W-1:0]    row_reg;

    logic                div_pend_reg;
    logic                div_busy_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [COL_W-1:0]    div_rem_reg;
    logic [POS_W-1:0]    div_quo_reg;

    logic [WIDTH_W-1:0]  eff_w;
    logic [HEIGHT_W-1:0] eff_h;
    logic [ROW_W-1:0]    row_h;
    logic [WIDTH_W:0]    span;
    logic [WIDTH_W-1:0]  base;
    logic [WIDTH_W:0]    sum_0;
    logic [WIDTH_W:0]    sum_r;
    logic [WIDTH_W:0]    sum_l;
    logic                first_c;
    logic                last_c;
    logic                first_r;
    logic                last_r;
    logic                has_result;
    logic                wrap;
    logic [WIDTH_W-1:0]  rem_sh;
    logic                rem_ge;
    logic [WIDTH_W-1:0]  rem_next;
    logic [POS_W-1:0]    quo_next;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_DX;
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            alpha_reg  <= ALPHA_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MODE:   mode_reg   <= cfg_data[MODE_W-1:0];
                REG_WIDTH:  width_reg  <= cfg_data[WIDTH_W-1:0];
                REG_HEIGHT: height_reg <= cfg_data[HEIGHT_W-1:0];
                REG_ALPHA:  alpha_reg  <= cfg_data[ALPHA_W-1:0];
            endcase
        end
    end

    assign cfg = '{mode: mode_reg, alpha: alpha_reg};

    // clamp width and height into their legal ranges
    always_comb
    begin
        priority if (width_reg < WIDTH_W'(2))
            eff_w = WIDTH_W'(2);
        else if (width_reg > WIDTH_W'(WIDTH_MAX))
            eff_w = WIDTH_W'(WIDTH_MAX);
        else
            eff_w = width_reg;

        priority if (height_reg == '0)
            eff_h = HEIGHT_W'(1);
        else if (height_reg > HEIGHT_W'(HEIGHT_MAX))
            eff_h = HEIGHT_W'(HEIGHT_MAX);
        else
            eff_h = height_reg;
    end

    // restoring divider step, one quotient bit a cycle
    assign rem_sh   = {div_rem_reg, div_quo_reg[POS_W-1]};
    assign rem_ge   = rem_sh >= eff_w;
    assign rem_next = rem_ge ? rem_sh - eff_w : rem_sh;
    assign quo_next = {div_quo_reg[POS_W-2:0], rem_ge};

    // classify the item at the current position
    always_comb
    begin
        row_h      = ROW_W'(eff_h);
        span       = {eff_w, 1'b0};
        first_c    = col_reg == '0;
        last_c     = {1'b0, col_reg} == eff_w - WIDTH_W'(1);
        first_r    = row_reg == ROW_W'(1);
        last_r     = row_reg == row_h;
        has_result = (row_reg != '0) && (row_reg <= row_h);
        wrap       = (row_reg > row_h) || (last_r && last_c);
        base       = {1'b0, col_reg} + (row_reg[0] ? eff_w : '0);
        sum_0      = {1'b0, base} + {1'b0, eff_w};
        sum_r      = sum_0 + (WIDTH_W+1)'(1);
        sum_l      = sum_0 - (WIDTH_W+1)'(1);
    end

    always_comb
    begin
        push_op.sample     = s_tdata[SAMPLE_W-1:0];
        push_op.addr_u     = base;
        push_op.addr_0     = (sum_0 >= span) ? ADDR_W'(sum_0 - span) : ADDR_W'(sum_0);
        push_op.addr_r     = (sum_r >= span) ? ADDR_W'(sum_r - span) : ADDR_W'(sum_r);
        push_op.addr_l     = (sum_l >= span) ? ADDR_W'(sum_l - span) : ADDR_W'(sum_l);
        push_op.has_result = has_result;
        push_op.first_c    = first_c;
        push_op.last_c     = last_c;
        push_op.first_r    = first_r;
        push_op.last_r     = last_r;
        push_op.frame_end  = last_r && last_c;
    end

    // handshake
    assign s_tready = !div_pend_reg && !div_busy_reg && !q_full;
    assign push     = s_tvalid && s_tready;

    assign stat = '{div_pend: div_pend_reg, div_busy: div_busy_reg};

    // position counters and re-division after a width change
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            col_reg      <= '0;
            row_reg      <= '0;
            div_pend_reg <= 1'b0;
            div_busy_reg <= 1'b0;
            div_cnt_reg  <= '0;
            div_rem_reg  <= '0;
            div_quo_reg  <= '0;
        end
        else
        begin
            div_pend_reg <= cfg_we && (cfg_index == REG_WIDTH);
            if (div_pend_reg)
            begin
                div_busy_reg <= 1'b1;
                div_cnt_reg  <= DIV_CNT_W'(POS_W);
                div_rem_reg  <= '0;
                div_quo_reg  <= pos_reg;
            end
            else if (div_busy_reg)
            begin
                div_rem_reg <= rem_next[COL_W-1:0];
                div_quo_reg <= quo_next;
                div_cnt_reg <= div_cnt_reg - DIV_CNT_W'(1);
                if (div_cnt_reg == DIV_CNT_W'(1))
                begin
                    div_busy_reg <= 1'b0;
                    col_reg      <= rem_next[COL_W-1:0];
                    row_reg      <= quo_next[ROW_W-1:0];
                end
            end
            else if (push)
            begin
                if (wrap)
                begin
                    pos_reg <= '0;
                    col_reg <= '0;
                    row_reg <= '0;
                end
                else
                begin
                    pos_reg <= pos_reg + POS_W'(1);
                    if (last_c)
                    begin
                        col_reg <= '0;
                        row_reg <= row_reg + ROW_W'(1);
                    end
                    else
                    begin
                        col_reg <= col_reg + COL_W'(1);
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/idop_queue.sv =====
// idop_queue: short fifo of classified items between front and back
// depends on idop_pkg for the item type and depth
`default_nettype none

module idop_queue (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          push,
    input  idop_pkg::idop_op_t           push_op,
    output logic                         full,
    input  wire                          pop,
    output idop_pkg::idop_op_t           head,
    output logic                         valid,
    output logic [idop_pkg::QPTR_W:0]    level
);
    import idop_pkg::*;

    idop_op_t          slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic              do_push;
    logic              do_pop;

    assign full    = count_reg == (QPTR_W+1)'(QUEUE_DEPTH);
    assign valid   = count_reg != '0;
    assign level   = count_reg;
    assign head    = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_op;
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + (QPTR_W+1)'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - (QPTR_W+1)'(1);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/idop_back.sv =====
// idop_back: two-row line store, operator sequencer, multiplier and output register
// depends on idop_pkg; takes classified items from idop_queue
`default_nettype none

module idop_back (
    input  wire                                clk,
    input  wire                                rst_n,
    input  idop_pkg::idop_cfg_t                cfg,
    input  wire                                q_valid,
    input  idop_pkg::idop_op_t                 q_head,
    output logic                               pop,
    output logic                               m_tvalid,
    input  wire                                m_tready,
    output logic [idop_pkg::TDATA_OUT_W-1:0]   m_tdata,
    output logic                               m_tlast
);
    import idop_pkg::*;

    localparam logic [1:0] S_RD0 = 2'd0;
    localparam logic [1:0] S_RD1 = 2'd1;
    localparam logic [1:0] S_OPR = 2'd2;
    localparam logic [1:0] S_MUL = 2'd3;

    function automatic logic signed [DIFF_W-1:0] sx(input logic [SAMPLE_W-1:0] v);
        sx = {{(DIFF_W-SAMPLE_W){v[SAMPLE_W-1]}}, v};
    endfunction

    logic [SAMPLE_W-1:0]          line_mem [LINE_DEPTH];
    logic [SAMPLE_W-1:0]          rd_a_reg;
    logic [SAMPLE_W-1:0]          rd_b_reg;
    logic [ADDR_W-1:0]            rd_addr_a;
    logic [ADDR_W-1:0]            rd_addr_b;
    logic                         mem_we;

    logic [1:0]                   state_reg;
    logic [1:0]                   state_next;
    idop_op_t                     op_reg;
    logic [SAMPLE_W-1:0]          xu_reg;
    logic [SAMPLE_W-1:0]          x0_reg;
    logic signed [DIFF_W-1:0]     diff_reg;
    logic signed [DIFF_W-1:0]     diff_next;
    logic                         second_reg;
    logic                         second_next;
    logic signed [ALPHA_SQ_W-1:0] alpha_sq_reg;
    logic signed [ALPHA_SQ_W-1:0] mult_a;
    logic signed [VALUE_W-1:0]    prod;
    logic [VALUE_W-1:0]           value_next;
    logic [VALUE_W-1:0]           value_reg;
    logic                         last_reg;
    logic                         valid_reg;
    logic                         out_free;

    logic signed [DIFF_W-1:0]     x0;
    logic signed [DIFF_W-1:0]     xu;
    logic signed [DIFF_W-1:0]     xr;
    logic signed [DIFF_W-1:0]     xl;
    logic signed [DIFF_W-1:0]     xd;
    logic signed [DIFF_W-1:0]     up;
    logic signed [DIFF_W-1:0]     down;
    logic signed [DIFF_W-1:0]     x0_cut;
    logic signed [DIFF_W-1:0]     kx0;

    assign out_free = !valid_reg || m_tready;
    assign pop      = (state_reg == S_RD0) && q_valid;
    assign mem_we   = state_reg == S_RD1;

    // first pass reads above and center taps, second pass the side taps
    assign rd_addr_a = (state_reg == S_RD0) ? q_head.addr_u : op_reg.addr_r;
    assign rd_addr_b = (state_reg == S_RD0) ? q_head.addr_0 : op_reg.addr_l;

    // line store: one write, two registered reads
    always_ff @(posedge clk)
    begin
        if (mem_we)
            line_mem[op_reg.addr_u] <= op_reg.sample;
        rd_a_reg <= line_mem[rd_addr_a];
        rd_b_reg <= line_mem[rd_addr_b];
    end

    // operand selection per operator
    always_comb
    begin
        x0     = sx(x0_reg);
        xu     = sx(xu_reg);
        xr     = sx(rd_a_reg);
        xl     = sx(rd_b_reg);
        xd     = sx(op_reg.sample);
        up     = op_reg.first_r ? '0 : xu;
        down   = op_reg.last_r ? '0 : xd;
        x0_cut = op_reg.last_r ? '0 : x0;
        if (op_reg.first_r && op_reg.last_r)
            kx0 = '0;
        else if (op_reg.first_r || op_reg.last_r)
            kx0 = x0;
        else
            kx0 = x0 <<< 1;

        diff_next   = '0;
        second_next = 1'b0;
        unique case (cfg.mode)
            MODE_DX:
                diff_next = op_reg.last_c ? '0 : xr - x0;
            MODE_DX_T:
            begin
                if (op_reg.first_c)
                    diff_next = -x0;
                else if (op_reg.last_c)
                    diff_next = xl;
                else
                    diff_next = xl - x0;
            end
            MODE_DX_SEC:
            begin
                second_next = 1'b1;
                if (op_reg.first_c)
                    diff_next = x0 - xr;
                else if (op_reg.last_c)
                    diff_next = x0 - xl;
                else
                    diff_next = (x0 <<< 1) - xl - xr;
            end
            MODE_DY:
                diff_next = op_reg.last_r ? '0 : xd - x0;
            MODE_DY_T:
                diff_next = up - x0_cut;
            MODE_DY_SEC:
            begin
                second_next = 1'b1;
                diff_next   = kx0 - up - down;
            end
            default:
                diff_next = '0;
        endcase
    end

    // scale: alpha with 12 fraction bits restored, or alpha squared
    assign mult_a     = second_reg ? alpha_sq_reg
                                   : {{(ALPHA_SQ_W-ALPHA_W){cfg.alpha[ALPHA_W-1]}}, cfg.alpha};
    assign prod       = mult_a * diff_reg;
    assign value_next = second_reg ? prod
                                   : {prod[VALUE_W-1-FRAC_SHIFT:0], {FRAC_SHIFT{1'b0}}};

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_RD0:
                if (q_valid)
                    state_next = S_RD1;
            S_RD1:
                state_next = op_reg.has_result ? S_OPR : S_RD0;
            S_OPR:
                state_next = S_MUL;
            S_MUL:
                if (out_free)
                    state_next = S_RD0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_RD0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == S_MUL) && out_free)
                valid_reg <= 1'b1;
            else if (m_tready)
                valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        alpha_sq_reg <= cfg.alpha * cfg.alpha;
        if (pop)
            op_reg <= q_head;
        if (state_reg == S_RD1)
        begin
            xu_reg <= rd_a_reg;
            x0_reg <= rd_b_reg;
        end
        if (state_reg == S_OPR)
        begin
            diff_reg   <= diff_next;
            second_reg <= second_next;
        end
        if ((state_reg == S_MUL) && out_free)
        begin
            value_reg <= value_next;
            last_reg  <= op_reg.frame_end;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(TDATA_OUT_W-VALUE_W){1'b0}}, value_reg};
    assign m_tlast  = last_reg;

endmodule

`default_nettype wire

// ===== rtl/image_difference_operators.sv =====
// image_difference_operators: top level of the streaming image difference block
// depends on idop_pkg, idop_front, idop_queue, idop_back
//
//  channel   direction  payload (low bit up)            handshake
//  s_*       in         tdata: sample[15:0]             tvalid/tready
//  m_*       out        tdata: value[49:0], pad; tlast  tvalid/tready
//                       tlast: frame_end
//  cfg_*     in         index 0 mode, 1 width,          write enable, no wait
//                       2 height, 3 alpha
//
// each item passes S_RD0, S_RD1 in the back sequencer (two line-store read passes
// over two read ports); one yielding a result also S_OPR (operand select), S_MUL
// (multiply); after a width write the input stalls while the position is re-divided
// reset clears counters and control; the line store is not cleared
// the output register and a 4-entry queue let input and output stall independently
`default_nettype none

module image_difference_operators (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                cfg_we,
    input  wire [idop_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire [idop_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire                                s_tvalid,
    output logic                               s_tready,
    input  wire [idop_pkg::TDATA_IN_W-1:0]     s_tdata,   // sample[15:0]
    output logic                               m_tvalid,
    input  wire                                m_tready,
    output logic [idop_pkg::TDATA_OUT_W-1:0]   m_tdata,   // value[49:0], zeros[55:50]
    output logic                               m_tlast
);
    import idop_pkg::*;

    logic              push;
    idop_op_t          push_op;
    logic              q_full;
    logic              q_valid;
    idop_op_t          q_head;
    logic              pop;
    logic [QPTR_W:0]   q_level;
    idop_cfg_t         cfg;
    idop_stat_t        stat;

    // front: config, counters, classification
    idop_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_full    (q_full),
        .push      (push),
        .push_op   (push_op),
        .cfg       (cfg),
        .stat      (stat)
    );

    // queue between front and back
    idop_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .full    (q_full),
        .pop     (pop),
        .head    (q_head),
        .valid   (q_valid),
        .level   (q_level)
    );

    // back: line store, arithmetic, output
    idop_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .q_valid  (q_valid),
        .q_head   (q_head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // input not ready while the position is being re-divided
    a_div_blocks_input : assert property (@(posedge clk) disable iff (!rst_n)
        (stat.div_pend || stat.div_busy) |-> !s_tready)
        else $error("input accepted during position re-division");

    // a width write stalls the input on the next cycle
    a_width_write_stalls : assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_we && (cfg_index == REG_WIDTH)) |=> !s_tready)
        else $error("input not stalled after width write");

    // queue never holds more than its depth
    a_queue_bound : assert property (@(posedge clk) disable iff (!rst_n)
        q_level <= (QPTR_W+1)'(QUEUE_DEPTH))
        else $error("queue level beyond depth");

endmodule

`default_nettype wire
